[sv/hft_pkg.sv]
package hft_pkg;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCAN,
    S_CMP,
    S_FINISH,
    S_CLEAR
  } state_t;

  localparam int TopOctetShift = 24;
  localparam int CountWidth    = 11;

endpackage

[sv/hashed_flow_table.sv]
// Channel  | Ports                                                 | Handshake
// command  | mode, local_addr, remote_addr, local/remote_port_num, | start & !busy
//          | sent_bytes_in                                         |
// result   | status, sent_bytes_out, flow_total                    | done (1 cycle)
//
// Search, insert and delete hold busy while four passes of one shared 32x32 multiplier
// build the bucket hash (two more passes when HASH_BUCKETS is not a power of two,
// reciprocal multiply and back-multiply for the modulo), then each way of the bucket
// is read (S_SCAN) and compared (S_CMP) in turn. Clear holds busy while the valid
// bits are swept one entry per cycle. Reset clears the valid bits the same way, busy
// held until the sweep ends. The receiver cannot stall.
module hashed_flow_table
  import hft_pkg::*;
#(
  parameter int HASH_BUCKETS = 256,
  parameter int BUCKET_WAYS  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            mode,
  input  logic [31:0]           local_addr,
  input  logic [31:0]           remote_addr,
  input  logic [15:0]           local_port_num,
  input  logic [15:0]           remote_port_num,
  input  logic [31:0]           sent_bytes_in,
  output logic                  done,
  output logic [1:0]            status,
  output logic [31:0]           sent_bytes_out,
  output logic [CountWidth-1:0] flow_total
);

  localparam int Slots  = HASH_BUCKETS * BUCKET_WAYS;
  localparam int SlotW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int BktW   = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
  localparam int WayCW  = $clog2(BUCKET_WAYS + 1);
  localparam logic BktPow2 = ((HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0);
  localparam logic [2:0] MulLast = BktPow2 ? 3'd3 : 3'd5;
  localparam logic [63:0] RecipFull = (64'd1 << 32) / 64'(HASH_BUCKETS);
  localparam logic [31:0] Recip = RecipFull[31:0];

  state_t state, state_next;
  logic   sweep_init;

  // item registers
  mode_t       op;
  logic [95:0] key;
  logic [31:0] bytes_in;

  // hash datapath: one shared multiplier
  logic [31:0] prod;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [2:0]  mul_step;
  logic [31:0] mul_a;
  logic [31:0] mul_opnd;
  logic [63:0] mul_full;
  logic [BktW-1:0] bucket;

  // way scan
  logic [WayCW-1:0] way;
  logic             hit;
  logic [SlotW-1:0] hit_slot;
  logic             free_found;
  logic [SlotW-1:0] free_slot;
  logic [SlotW-1:0] rd_slot;

  // memories and valid bits
  logic [95:0] key_mem   [Slots];
  logic [31:0] bytes_mem [Slots];
  logic [95:0] key_rd;
  logic [31:0] bytes_rd;
  logic [Slots-1:0] valid;
  logic             valid_rd;
  logic [SlotW:0]   clr_cnt;
  logic [CountWidth-1:0] count;

  logic accept;
  assign accept = start && !busy;

  // select multiplier operands for this pass
  always_comb begin
    mul_a = prod;
    unique case (mul_step)
      3'd0: mul_opnd = 32'(key[95:64] >> TopOctetShift) + 32'd1;
      3'd1: mul_opnd = 32'(key[63:32] >> TopOctetShift) + 32'd1;
      3'd2: mul_opnd = 32'(key[31:16]) + 32'd1;
      3'd3: mul_opnd = 32'(key[15:0]) + 32'd1;
      3'd4: mul_opnd = Recip;
      default: begin
        mul_a    = quo;
        mul_opnd = 32'(HASH_BUCKETS);
      end
    endcase
    mul_full = 64'(mul_a) * 64'(mul_opnd);
  end

  // bucket is a mask when power of two, else hash minus quotient times buckets
  always_comb begin
    rem = prod - quo;
    if (BktPow2) bucket = BktW'(prod & 32'(HASH_BUCKETS - 1));
    else if (rem >= 32'(HASH_BUCKETS)) bucket = BktW'(rem - 32'(HASH_BUCKETS));
    else bucket = BktW'(rem);
  end

  always_comb begin
    rd_slot = SlotW'(32'(bucket) * 32'(BUCKET_WAYS) + 32'(way));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = (mode_t'(mode) == MODE_CLEAR) ? S_CLEAR : S_MUL;
      S_MUL:    if (mul_step == MulLast) state_next = S_SCAN;
      S_SCAN:   state_next = S_CMP;
      S_CMP:    if (32'(way) + 32'd1 >= 32'(BUCKET_WAYS)) state_next = S_FINISH;
                else state_next = S_SCAN;
      S_FINISH: state_next = S_IDLE;
      S_CLEAR:  if (32'(clr_cnt) + 32'd1 >= 32'(Slots)) begin
                  state_next = sweep_init ? S_IDLE : S_FINISH;
                end
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy = (state != S_IDLE);
  end

  // the sweep after reset gives no result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      op         <= MODE_CLEAR;
      sweep_init <= 1'b1;
    end else begin
      state <= state_next;
      if (accept) begin
        op         <= mode_t'(mode);
        sweep_init <= 1'b0;
      end
    end
  end

  // capture item; run the hash multiply and the modulo passes
  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= {local_addr, remote_addr, local_port_num, remote_port_num};
      bytes_in <= sent_bytes_in;
      prod     <= 32'd1;
      quo      <= 32'd0;
      mul_step <= 3'd0;
      way      <= '0;
    end else if (state == S_MUL) begin
      if (mul_step <= 3'd3) prod <= mul_full[31:0];
      else if (mul_step == 3'd4) quo <= mul_full[63:32];
      else quo <= mul_full[31:0];
      mul_step <= mul_step + 3'd1;
    end else if (state == S_CMP) begin
      way <= way + WayCW'(1);
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    key_rd   <= key_mem[rd_slot];
    bytes_rd <= bytes_mem[rd_slot];
    valid_rd <= valid[rd_slot];
  end

  // compare one way; remember first hit and first free way
  always_ff @(posedge clk) begin
    if (accept) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_CMP) begin
      if (valid_rd && key_rd == key && !hit) begin
        hit      <= 1'b1;
        hit_slot <= rd_slot;
      end
      if (!valid_rd && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= rd_slot;
      end
    end
  end

  // write memories on insert
  always_ff @(posedge clk) begin
    if (state == S_FINISH && op == MODE_INSERT && !hit && free_found) begin
      key_mem[free_slot]   <= key;
      bytes_mem[free_slot] <= bytes_in;
    end
  end

  // delete needs stored bytes of the hit slot
  logic [31:0] hit_bytes;
  always_ff @(posedge clk) begin
    if (state == S_CMP && valid_rd && key_rd == key && !hit) hit_bytes <= bytes_rd;
  end

  // valid bits, counter and clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      count   <= '0;
    end else if (accept) begin
      clr_cnt <= '0;
    end else if (state == S_CLEAR) begin
      valid[clr_cnt[SlotW-1:0]] <= 1'b0;
      clr_cnt <= clr_cnt + 1'b1;
      count   <= '0;
    end else if (state == S_FINISH) begin
      if (op == MODE_INSERT && !hit && free_found) begin
        valid[free_slot] <= 1'b1;
        count <= count + 1'b1;
      end else if (op == MODE_DELETE && hit) begin
        valid[hit_slot] <= 1'b0;
        count <= count - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
    end
  end

  logic [1:0]  status_next;
  logic [31:0] bytes_next;
  logic [CountWidth-1:0] count_next;
  always_comb begin
    status_next = ST_OK;
    bytes_next  = '0;
    count_next  = count;
    unique case (op)
      MODE_SEARCH: if (hit) bytes_next = hit_bytes; else status_next = ST_NOT_FOUND;
      MODE_INSERT: begin
        if (hit) status_next = ST_DUPLICATE;
        else if (!free_found) status_next = ST_FULL;
        else count_next = count + 1'b1;
      end
      MODE_DELETE: begin
        if (hit) begin
          bytes_next = (hit_bytes == 32'd0) ? 32'd1 : hit_bytes;
          count_next = count - 1'b1;
        end else status_next = ST_NOT_FOUND;
      end
      default: count_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      status         <= status_next;
      sent_bytes_out <= bytes_next;
      flow_total     <= count_next;
    end
  end

endmodule

[verif/tb_hashed_flow_table.sv]
`timescale 1ns / 100ps

module tb_hashed_flow_table
  import hft_pkg::*;
();

  localparam int NumBuckets = 256;
  localparam int NumWays    = 4;
  localparam int NumSlots   = NumBuckets * NumWays;
  localparam int CycleLimit = 4000000;

  typedef struct packed {
    logic [31:0] laddr;
    logic [31:0] raddr;
    logic [15:0] lport;
    logic [15:0] rport;
  } flow_key_t;

  typedef struct {
    status_t     status;
    logic [31:0] bytes;
    logic [10:0] total;
  } flow_reply_t;

  // Flow table model plus the queue of replies it predicts
  class flow_table_board;
    bit             slot_valid[NumSlots];
    flow_key_t      slot_key[NumSlots];
    logic [31:0]    slot_bytes[NumSlots];
    logic [10:0]    flow_count;
    flow_reply_t    pending_replies[$];
    int             error_count;
    int             reply_count;
    int             mode_seen[4];
    int             status_seen[4];

    function new();
      flow_count = '0;
      error_count = 0;
      reply_count = 0;
    endfunction

    function int bucket_of(flow_key_t k);
      logic [31:0] prod;
      prod = {24'd0, k.laddr[31:TopOctetShift]} + 32'd1;
      prod = prod * ({24'd0, k.raddr[31:TopOctetShift]} + 32'd1);
      prod = prod * ({16'd0, k.lport} + 32'd1);
      prod = prod * ({16'd0, k.rport} + 32'd1);
      return int'(prod % NumBuckets);
    endfunction

    function int find_slot(int bkt, flow_key_t k);
      for (int w = 0; w < NumWays; w++) begin
        if (slot_valid[bkt*NumWays+w] && slot_key[bkt*NumWays+w] == k) return bkt*NumWays+w;
      end
      return -1;
    endfunction

    // Apply one accepted item and queue its reply
    function void note_item(mode_t md, flow_key_t k, logic [31:0] bytes_in);
      flow_reply_t r;
      int bkt;
      int s;
      bkt = bucket_of(k);
      r.status = ST_OK;
      r.bytes = '0;
      mode_seen[md]++;
      case (md)
        MODE_SEARCH: begin
          s = find_slot(bkt, k);
          if (s < 0) r.status = ST_NOT_FOUND;
          else r.bytes = slot_bytes[s];
        end
        MODE_INSERT: begin
          if (find_slot(bkt, k) >= 0) r.status = ST_DUPLICATE;
          else begin
            r.status = ST_FULL;
            for (int w = 0; w < NumWays; w++) begin
              s = bkt*NumWays + w;
              if (!slot_valid[s]) begin
                slot_valid[s] = 1'b1;
                slot_key[s] = k;
                slot_bytes[s] = bytes_in;
                flow_count = flow_count + 11'd1;
                r.status = ST_OK;
                break;
              end
            end
          end
        end
        MODE_DELETE: begin
          s = find_slot(bkt, k);
          if (s < 0) r.status = ST_NOT_FOUND;
          else begin
            r.bytes = (slot_bytes[s] == 0) ? 32'd1 : slot_bytes[s];
            slot_valid[s] = 1'b0;
            flow_count = flow_count - 11'd1;
          end
        end
        default: begin
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
          flow_count = '0;
        end
      endcase
      r.total = flow_count;
      pending_replies.push_back(r);
    endfunction

    // Compare one reply with the oldest prediction
    function void check_reply(logic [1:0] st, logic [31:0] bytes, logic [10:0] total);
      flow_reply_t e;
      reply_count++;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d bytes %0h total %0d", st, bytes, total);
        error_count++;
        return;
      end
      e = pending_replies.pop_front();
      status_seen[e.status]++;
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        error_count++;
      end
      if (bytes !== e.bytes) begin
        $error("sent_bytes_out: expected %0h, actual %0h", e.bytes, bytes);
        error_count++;
      end
      if (total !== e.total) begin
        $error("flow_total: expected %0d, actual %0d", e.total, total);
        error_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [31:0] local_addr;
  logic [31:0] remote_addr;
  logic [15:0] local_port_num;
  logic [15:0] remote_port_num;
  logic [31:0] sent_bytes_in;
  logic        done;
  logic [1:0]  status;
  logic [31:0] sent_bytes_out;
  logic [CountWidth-1:0] flow_total;

  flow_table_board board;
  flow_key_t       key_pool[$];
  int              cycle_count;
  bit              gaps_on;

  hashed_flow_table #(
    .HASH_BUCKETS(NumBuckets),
    .BUCKET_WAYS (NumWays)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .local_addr     (local_addr),
    .remote_addr    (remote_addr),
    .local_port_num (local_port_num),
    .remote_port_num(remote_port_num),
    .sent_bytes_in  (sent_bytes_in),
    .done           (done),
    .status         (status),
    .sent_bytes_out (sent_bytes_out),
    .flow_total     (flow_total)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Check each reply on the edge that ends its strobe cycle
  always @(posedge clk) begin
    if (!rst && done) board.check_reply(status, sent_bytes_out, flow_total);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one item, holding start until the block accepts it
  task automatic send_item(mode_t md, flow_key_t k, logic [31:0] bytes_in);
    if (gaps_on && ($urandom_range(0, 3) == 0)) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start           <= 1'b1;
    mode            <= md;
    local_addr      <= k.laddr;
    remote_addr     <= k.raddr;
    local_port_num  <= k.lport;
    remote_port_num <= k.rport;
    sent_bytes_in   <= bytes_in;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(md, k, bytes_in);
  endtask

  task automatic drop_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Build a random key, sometimes crowding a few hot buckets
  function automatic flow_key_t rand_key();
    flow_key_t k;
    k = {$urandom, $urandom, 16'($urandom), 16'($urandom)};
    if ($urandom_range(0, 2) == 0) begin
      k.laddr[31:24] = 8'd0;
      k.raddr[31:24] = 8'd0;
      k.lport = 16'($urandom_range(0, 1)) * 16'd255;
      k.rport = 16'd0;
    end
    return k;
  endfunction

  // Key mostly reused from earlier inserts, so searches and deletes can hit
  function automatic flow_key_t pick_key();
    if (key_pool.size() == 0 || $urandom_range(0, 4) == 0) return rand_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  initial begin
    flow_key_t k;
    int        roll;
    mode_t     md;
    board = new();
    cycle_count = 0;
    gaps_on = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_SEARCH;
    local_addr = '0;
    remote_addr = '0;
    local_port_num = '0;
    remote_port_num = '0;
    sent_bytes_in = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, duplicate, full bucket, zero-byte delete, clear
    k = '0;
    send_item(MODE_SEARCH, k, 32'hFFFF_FFFF);
    send_item(MODE_INSERT, k, 32'd0);
    send_item(MODE_INSERT, k, 32'd5);
    send_item(MODE_SEARCH, k, 32'd0);
    send_item(MODE_DELETE, k, 32'd0);
    send_item(MODE_DELETE, k, 32'd0);
    k = '1;
    send_item(MODE_INSERT, k, 32'hFFFF_FFFF);
    send_item(MODE_SEARCH, k, 32'd0);
    // Keys differing only in low address bits share a bucket
    for (int i = 0; i < NumWays + 1; i++) begin
      k = {32'h0000_0000 + i, 32'h00FF_FFF0 - i, 16'd0, 16'd0};
      send_item(MODE_INSERT, k, 32'h100 + i);
    end
    k = {32'h0000_0002, 32'h00FF_FFEE, 16'd0, 16'd0};
    send_item(MODE_DELETE, k, 32'd0);
    k = {32'h0000_0004, 32'h00FF_FFEC, 16'd0, 16'd0};
    send_item(MODE_INSERT, k, 32'h8000_0000);
    send_item(MODE_SEARCH, k, 32'd0);
    send_item(MODE_CLEAR, '1, 32'hFFFF_FFFF);
    send_item(MODE_SEARCH, k, 32'd0);
    send_item(MODE_DELETE, '1, 32'd0);
    drop_start();

    // Random: inserts, lookups and deletes, mostly of known keys, with clears now and then
    gaps_on = 1'b1;
    for (int n = 0; n < 600; n++) begin
      if (n == 300) begin
        // Hold off until every reply is in
        start <= 1'b0;
        while (board.pending_replies.size() != 0) @(posedge clk);
      end
      if (n == 520) gaps_on = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        md = MODE_INSERT;
        k = rand_key();
        if ($urandom_range(0, 5) == 0) k = pick_key();
        else key_pool.push_back(k);
      end else if (roll < 70) begin
        md = MODE_SEARCH;
        k = pick_key();
      end else if (roll < 97) begin
        md = MODE_DELETE;
        k = pick_key();
      end else begin
        md = MODE_CLEAR;
        k = rand_key();
      end
      send_item(md, k, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
    end
    start <= 1'b0;

    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (NumSlots + 20) @(posedge clk);

    $display("Covered %0d replies: %0d searches, %0d inserts, %0d deletes, %0d clears.",
             board.reply_count, board.mode_seen[0], board.mode_seen[1],
             board.mode_seen[2], board.mode_seen[3]);
    $display("Statuses seen: ok %0d, miss %0d, duplicate %0d, bucket full %0d.",
             board.status_seen[0], board.status_seen[1],
             board.status_seen[2], board.status_seen[3]);
    if (board.error_count == 0 && board.pending_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
sv/hft_pkg.sv
sv/hashed_flow_table.sv
verif/tb_hashed_flow_table.sv
